### rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int CFP_W   = 5;
  localparam int CNT_W   = 3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_code_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] start;
    logic [SLOT_W-1:0] len;
    logic              dir;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_REPORT,
    OP_CLEAR,
    OP_COMMIT,
    OP_SCAN_NEXT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
    logic       zero_count;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      len_bad;
    logic      no_room;
    logic      scan_end;
    logic      match;
    logic      emit_empty;
    logic      out_last;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              entry_valid;
    logic [CNT_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_address;
    logic [SLOT_W-1:0] entry_start_slot;
    logic [SLOT_W-1:0] entry_length;
    logic              entry_direction;
    logic [CNT_W-1:0]  entry_count;
    logic [CFP_W-1:0]  cfp_start;
    logic              last;
  } out_t;

endpackage

### rtl/gsa_in_if.sv
interface gsa_in_if import gsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] short_addr;
  logic [LEN_W-1:0]  slot_length;
  logic              direction;

  modport source (output valid, cmd, short_addr, slot_length, direction, input ready);
  modport sink (input valid, cmd, short_addr, slot_length, direction, output ready);
endinterface

### rtl/gsa_out_if.sv
interface gsa_out_if import gsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              entry_valid;
  logic [CNT_W-1:0]  entry_index;
  logic [ADDR_W-1:0] entry_address;
  logic [SLOT_W-1:0] entry_start_slot;
  logic [SLOT_W-1:0] entry_length;
  logic              entry_direction;
  logic [CNT_W-1:0]  entry_count;
  logic [CFP_W-1:0]  cfp_start;
  logic              last;

  modport source (output valid, status, entry_valid, entry_index, entry_address,
                  entry_start_slot, entry_length, entry_direction, entry_count,
                  cfp_start, last, input ready);
  modport sink (input valid, status, entry_valid, entry_index, entry_address,
                entry_start_slot, entry_length, entry_direction, entry_count,
                cfp_start, last, output ready);
endinterface

### rtl/gsa_cfg_if.sv
interface gsa_cfg_if;
  logic valid;
  logic ready;
  logic gts_permit;

  modport source (output valid, gts_permit, input ready);
  modport sink (input valid, gts_permit, output ready);
endinterface

### rtl/gsa_dpath.sv
module gsa_dpath import gsa_pkg::*; #(
  parameter int MAX_ENTRIES = 7,
  parameter int LAST_SLOT   = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_cmd,
  input  logic [ADDR_W-1:0] in_short_addr,
  input  logic [LEN_W-1:0]  in_slot_length,
  input  logic              in_direction,
  input  logic              cfg_we,
  input  logic              cfg_permit,
  input  dp_cmd_t           dcmd,
  output dp_stat_t          dstat,
  output out_t              out_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CFP_W-1:0] CFP_RESET = CFP_W'(LAST_SLOT + 1);

  entry_t            tbl_r [MAX_ENTRIES];
  logic [CNT_W-1:0]  count_r;
  logic [CFP_W-1:0]  cfp_r;
  logic              permit_r;
  cmd_code_t         code_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic              dir_r;
  logic [CNT_W-1:0]  idx_r;
  out_t              out_r;
  out_t              out_nxt;

  entry_t            cur;
  logic [CFP_W-1:0]  cfp_nxt;

  assign cur     = tbl_r[idx_r[AW-1:0]];
  assign cfp_nxt = cfp_r - len_r[CFP_W-1:0];

  always_comb begin
    dstat.code       = code_r;
    dstat.len_bad    = (len_r == '0) || (len_r > LEN_W'(LAST_SLOT));
    // One slot must remain for the contention access period.
    dstat.no_room    = (count_r >= CNT_W'(MAX_ENTRIES)) ||
                       ({{(LEN_W+1-CFP_W){1'b0}}, cfp_r} < ({1'b0, len_r} + 9'd1));
    dstat.scan_end   = (idx_r == count_r);
    dstat.match      = (cur.addr == addr_r) && (cur.dir == dir_r);
    dstat.emit_empty = !permit_r || (count_r == '0);
    dstat.out_last   = out_r.last;
  end

  assign out_data = out_r;

  always_comb begin
    out_nxt = out_r;
    case (dcmd.op)
      OP_REPORT: begin
        out_nxt             = '0;
        out_nxt.status      = dcmd.status;
        out_nxt.entry_count = dcmd.zero_count ? '0 : count_r;
        out_nxt.cfp_start   = cfp_r;
        out_nxt.last        = 1'b1;
      end
      OP_CLEAR: begin
        out_nxt           = '0;
        out_nxt.status    = ST_OK;
        out_nxt.cfp_start = CFP_RESET;
        out_nxt.last      = 1'b1;
      end
      OP_COMMIT: begin
        out_nxt             = '0;
        out_nxt.status      = ST_OK;
        out_nxt.entry_count = count_r + 3'd1;
        out_nxt.cfp_start   = cfp_nxt;
        out_nxt.last        = 1'b1;
      end
      OP_EMIT: begin
        out_nxt.status           = ST_OK;
        out_nxt.entry_valid      = 1'b1;
        out_nxt.entry_index      = idx_r;
        out_nxt.entry_address    = cur.addr;
        out_nxt.entry_start_slot = cur.start;
        out_nxt.entry_length     = cur.len;
        out_nxt.entry_direction  = cur.dir;
        out_nxt.entry_count      = count_r;
        out_nxt.cfp_start        = cfp_r;
        out_nxt.last             = (idx_r + 3'd1 == count_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cfp_r    <= CFP_RESET;
      permit_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        permit_r <= cfg_permit;
      end
      case (dcmd.op)
        OP_CLEAR: begin
          count_r <= '0;
          cfp_r   <= CFP_RESET;
        end
        OP_COMMIT: begin
          count_r <= count_r + 3'd1;
          cfp_r   <= cfp_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    case (dcmd.op)
      OP_CAPTURE: begin
        code_r <= cmd_code_t'(in_cmd);
        addr_r <= in_short_addr;
        len_r  <= in_slot_length;
        dir_r  <= in_direction;
        idx_r  <= '0;
      end
      OP_COMMIT: begin
        tbl_r[count_r[AW-1:0]] <= '{addr: addr_r, start: cfp_nxt[SLOT_W-1:0],
                                    len: len_r[SLOT_W-1:0], dir: dir_r};
      end
      OP_SCAN_NEXT: begin
        idx_r <= idx_r + 3'd1;
      end
      OP_EMIT: begin
        idx_r <= idx_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/gsa_ctrl.sv
module gsa_ctrl import gsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  dcmd,
  input  dp_stat_t dstat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EMIT,
    S_EOUT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT) || (state_r == S_EOUT);

  always_comb begin
    state_nxt       = state_r;
    dcmd.op         = OP_NONE;
    dcmd.status     = ST_OK;
    dcmd.zero_count = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op   = OP_CAPTURE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        case (dstat.code)
          CMD_ADD: begin
            if (dstat.len_bad) begin
              dcmd.op     = OP_REPORT;
              dcmd.status = ST_INVALID;
            end else if (dstat.no_room) begin
              dcmd.op     = OP_REPORT;
              dcmd.status = ST_TOO_LARGE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_CLEAR: begin
            dcmd.op = OP_CLEAR;
          end
          CMD_EMIT: begin
            if (dstat.emit_empty) begin
              dcmd.op         = OP_REPORT;
              dcmd.zero_count = 1'b1;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: begin
            dcmd.op     = OP_REPORT;
            dcmd.status = ST_INVALID;
          end
        endcase
      end
      S_SCAN: begin
        // Walk the stored entries one per cycle looking for a duplicate.
        if (dstat.scan_end) begin
          dcmd.op   = OP_COMMIT;
          state_nxt = S_OUT;
        end else if (dstat.match) begin
          dcmd.op     = OP_REPORT;
          dcmd.status = ST_PRESENT;
          state_nxt   = S_OUT;
        end else begin
          dcmd.op = OP_SCAN_NEXT;
        end
      end
      S_EMIT: begin
        dcmd.op   = OP_EMIT;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          state_nxt = dstat.out_last ? S_IDLE : S_EMIT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/gts_slot_allocator.sv
// Guaranteed-time-slot table for a superframe coordinator.
// The in_ch channel takes one command per transaction: add an entry for a
// device address and direction, clear the table, or emit the stored list.
// Every add, clear or reserved command returns one transaction on out_ch;
// an emit returns one transaction per stored entry in insertion order, or a
// single empty one when the permit is off or the table is empty. The last
// flag marks the final result of a command.
// The cfg_ch channel writes the one-bit GTS permit and is always ready.
// Commands are handled one at a time; in_ch.ready is high only when idle.
// A clear or a rejected add goes from decode straight to its result. An add
// scans the table one entry per cycle for a duplicate before it commits.
// An emit registers one result at a time and prepares the next only after
// the previous one is accepted. The next command is taken in the cycle after the
// last result of a command is accepted. With a stalled receiver the result
// is held on out_ch and no new command is taken.
// Reset empties the table, puts the contention-free period start at
// LAST_SLOT + 1 and sets the permit.
module gts_slot_allocator import gsa_pkg::*; #(
  parameter int MAX_ENTRIES = 7,
  parameter int LAST_SLOT   = 15
) (
  input logic      clk,
  input logic      rst_n,
  gsa_in_if.sink   in_ch,
  gsa_out_if.source out_ch,
  gsa_cfg_if.sink  cfg_ch
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  out_t     out_data;

  assign cfg_ch.ready = 1'b1;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dcmd      (dcmd),
    .dstat     (dstat)
  );

  gsa_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .LAST_SLOT   (LAST_SLOT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_ch.cmd),
    .in_short_addr  (in_ch.short_addr),
    .in_slot_length (in_ch.slot_length),
    .in_direction   (in_ch.direction),
    .cfg_we         (cfg_ch.valid),
    .cfg_permit     (cfg_ch.gts_permit),
    .dcmd           (dcmd),
    .dstat          (dstat),
    .out_data       (out_data)
  );

  assign out_ch.status           = out_data.status;
  assign out_ch.entry_valid      = out_data.entry_valid;
  assign out_ch.entry_index      = out_data.entry_index;
  assign out_ch.entry_address    = out_data.entry_address;
  assign out_ch.entry_start_slot = out_data.entry_start_slot;
  assign out_ch.entry_length     = out_data.entry_length;
  assign out_ch.entry_direction  = out_data.entry_direction;
  assign out_ch.entry_count      = out_data.entry_count;
  assign out_ch.cfp_start        = out_data.cfp_start;
  assign out_ch.last             = out_data.last;

endmodule

### bench/tb.sv
module tb import gsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 7;
  localparam int LAST_SLOT   = 15;

  // Tracks the slot table and keeps the results each accepted command should produce.
  class gts_table_model;
    entry_t      entries[TABLE_DEPTH];
    int unsigned n_entries;
    int unsigned cfp_first;
    bit          permit;
    out_t        expected_q[$];
    int          mismatches;

    function new();
      n_entries  = 0;
      cfp_first  = LAST_SLOT + 1;
      permit     = 1'b1;
      mismatches = 0;
    endfunction

    function void set_permit(bit value);
      permit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function out_t make_result(logic [1:0] st, bit has_entry, int unsigned idx, entry_t e,
                               int unsigned cnt, bit is_last);
      out_t r;
      r = '0;
      r.status      = st;
      r.entry_count = CNT_W'(cnt);
      r.cfp_start   = CFP_W'(cfp_first);
      r.last        = is_last;
      if (has_entry) begin
        r.entry_valid      = 1'b1;
        r.entry_index      = CNT_W'(idx);
        r.entry_address    = e.addr;
        r.entry_start_slot = e.start;
        r.entry_length     = e.len;
        r.entry_direction  = e.dir;
      end
      return r;
    endfunction

    function void note_command(logic [1:0] cmd, logic [15:0] addr, logic [7:0] len,
                               logic dir);
      logic [1:0] st;
      bit         dup;
      case (cmd)
        CMD_ADD: begin
          dup = 1'b0;
          for (int i = 0; i < n_entries; i++)
            if (entries[i].addr == addr && entries[i].dir == dir) dup = 1'b1;
          // One slot has to stay free for the contention access period.
          if (len == 0 || len > LAST_SLOT) begin
            st = ST_INVALID;
          end else if (n_entries >= TABLE_DEPTH || cfp_first < len + 1) begin
            st = ST_TOO_LARGE;
          end else if (dup) begin
            st = ST_PRESENT;
          end else begin
            cfp_first -= len;
            entries[n_entries] = '{addr, SLOT_W'(cfp_first), SLOT_W'(len), dir};
            n_entries++;
            st = ST_OK;
          end
          expected_q.push_back(make_result(st, 1'b0, 0, '0, n_entries, 1'b1));
        end
        CMD_CLEAR: begin
          n_entries = 0;
          cfp_first = LAST_SLOT + 1;
          expected_q.push_back(make_result(ST_OK, 1'b0, 0, '0, 0, 1'b1));
        end
        CMD_EMIT: begin
          if (!permit || n_entries == 0) begin
            expected_q.push_back(make_result(ST_OK, 1'b0, 0, '0,
                                             permit ? n_entries : 0, 1'b1));
          end else begin
            for (int i = 0; i < n_entries; i++)
              expected_q.push_back(make_result(ST_OK, 1'b1, i, entries[i], n_entries,
                                               i == n_entries - 1));
          end
        end
        default: begin
          expected_q.push_back(make_result(ST_INVALID, 1'b0, 0, '0, n_entries, 1'b1));
        end
      endcase
    endfunction

    function string show(out_t r);
      return $sformatf({"st=%0d ev=%0d idx=%0d addr=%h start=%0d len=%0d dir=%0d",
                        " cnt=%0d cfp=%0d last=%0d"},
                       r.status, r.entry_valid, r.entry_index, r.entry_address,
                       r.entry_start_slot, r.entry_length, r.entry_direction,
                       r.entry_count, r.cfp_start, r.last);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: %s", $realtime, show(got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $realtime, show(want), show(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;

  gts_table_model alloc_pred;

  gsa_in_if  cmd_if ();
  gsa_out_if res_if ();
  gsa_cfg_if permit_if ();

  gts_slot_allocator #(
    .MAX_ENTRIES(TABLE_DEPTH),
    .LAST_SLOT  (LAST_SLOT)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_if),
    .out_ch(res_if),
    .cfg_ch(permit_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      alloc_pred.check_result({res_if.status, res_if.entry_valid, res_if.entry_index,
                               res_if.entry_address, res_if.entry_start_slot,
                               res_if.entry_length, res_if.entry_direction,
                               res_if.entry_count, res_if.cfp_start, res_if.last});
  end

  // The valid line is only touched at a falling edge, so a back-to-back command
  // keeps it high without a drop in between.
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] len, input logic dir);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= cmd;
    cmd_if.short_addr  <= addr;
    cmd_if.slot_length <= len;
    cmd_if.direction   <= dir;
    do @(posedge clk); while (!cmd_if.ready);
    alloc_pred.note_command(cmd, addr, len, dir);
  endtask

  task automatic settle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (alloc_pred.pending() != 0) @(posedge clk);
  endtask

  task automatic write_permit(input logic value);
    @(negedge clk);
    permit_if.valid      <= 1'b1;
    permit_if.gts_permit <= value;
    do @(posedge clk); while (!permit_if.ready);
    alloc_pred.set_permit(value);
    @(negedge clk);
    permit_if.valid <= 1'b0;
  endtask

  task automatic random_command();
    logic [15:0] addr_pool[8];
    logic [15:0] addr;
    logic [7:0]  len;
    logic [1:0]  cmd;
    int          pick;
    int          len_pick;
    addr_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h7FFF,
                  16'hBEEF, 16'h00FF};
    pick     = $urandom_range(99);
    len_pick = $urandom_range(99);
    // A small address pool makes duplicate requests common.
    addr = ($urandom_range(99) < 70) ? addr_pool[$urandom_range(7)] : 16'($urandom);
    if (len_pick < 80)
      len = 8'($urandom_range(4, 1));
    else if (len_pick < 90)
      len = 8'($urandom_range(15, 5));
    else
      len = 8'($urandom_range(255));
    if (pick < 55) begin
      cmd = CMD_ADD;
    end else if (pick < 63) begin
      cmd = CMD_CLEAR;
    end else if (pick < 85) begin
      cmd = CMD_EMIT;
    end else if (pick < 90) begin
      cmd = CMD_RSVD;
    end else begin
      cmd = CMD_ADD;
      len = 8'($urandom_range(255));
    end
    send_command(cmd, addr, len, 1'($urandom_range(1)));
  endtask

  initial begin
    alloc_pred           = new();
    tx_idle_pct          = 35;
    rx_idle_pct          = 53;
    rst_n                = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_ADD;
    cmd_if.short_addr    = '0;
    cmd_if.slot_length   = '0;
    cmd_if.direction     = 1'b0;
    permit_if.valid      = 1'b0;
    permit_if.gts_permit = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_permit(1'b1);
    send_command(CMD_EMIT, 16'h0000, 8'd0, 1'b0);
    send_command(CMD_ADD, 16'h0000, 8'd0, 1'b0);
    send_command(CMD_ADD, 16'hFFFF, 8'd16, 1'b1);
    send_command(CMD_ADD, 16'h5A5A, 8'd255, 1'b1);
    // Longest allowed request uses the whole period but one slot.
    send_command(CMD_ADD, 16'hFFFF, 8'd15, 1'b1);
    send_command(CMD_ADD, 16'h0001, 8'd1, 1'b0);
    send_command(CMD_EMIT, 16'hFFFF, 8'd255, 1'b1);
    send_command(CMD_CLEAR, 16'hFFFF, 8'd255, 1'b1);
    send_command(CMD_RSVD, 16'hFFFF, 8'd255, 1'b1);
    send_command(CMD_ADD, 16'h0000, 8'd1, 1'b0);
    send_command(CMD_ADD, 16'h0000, 8'd2, 1'b0);
    send_command(CMD_ADD, 16'h0000, 8'd2, 1'b1);
    for (int k = 0; k < 5; k++)
      send_command(CMD_ADD, 16'(16'h1111 * (k + 1)), 8'd1, k[0]);
    send_command(CMD_ADD, 16'hABCD, 8'd1, 1'b0);
    send_command(CMD_RSVD, 16'h0000, 8'd0, 1'b0);
    send_command(CMD_EMIT, 16'h0000, 8'd0, 1'b0);
    send_command(CMD_CLEAR, 16'h0000, 8'd0, 1'b0);
    send_command(CMD_EMIT, 16'h0000, 8'd0, 1'b0);
    settle();
    write_permit(1'b0);
    send_command(CMD_ADD, 16'hAAAA, 8'd3, 1'b1);
    send_command(CMD_EMIT, 16'h0000, 8'd0, 1'b0);
    settle();
    write_permit(1'b1);
    send_command(CMD_EMIT, 16'h0000, 8'd0, 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 53 : 0;
      rx_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 35 : 0;
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        write_permit(seg == 0);
        repeat (seg == 0 ? 100 : 60) random_command();
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (alloc_pred.mismatches == 0 && alloc_pred.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
